// File: hw/rtl/bba_pkg.sv
package bba_pkg;

  // tree geometry
  localparam int MAX_DEPTH  = 10;
  localparam int NODE_W     = MAX_DEPTH + 1;
  localparam int NODE_COUNT = 1 << NODE_W;
  localparam int LEN_W      = 5;
  localparam int CODE_W     = MAX_DEPTH;
  localparam int LVL_W      = $clog2(MAX_DEPTH + 1);
  localparam int SIB_W      = ($clog2(MAX_DEPTH) > 0) ? $clog2(MAX_DEPTH) : 1;

  localparam logic [LEN_W-1:0]  EXHAUSTED = 5'd31;
  localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DESC,
    ST_ASC,
    ST_DONE
  } state_t;

  // sequencer to tree memory
  typedef struct packed {
    logic [NODE_W-1:0] rd_addr_a;
    logic [NODE_W-1:0] rd_addr_b;
    logic              we;
    logic [NODE_W-1:0] wr_addr;
    logic [LEN_W-1:0]  wr_data;
  } mem_req_t;

endpackage

// File: hw/rtl/prefix_code_buddy_allocator_top.sv
// a request of length L walks through one root check, L descent steps, L ancestor
// rewrites and one result load, which waits while the result channel is stalled
// a failed request has only the root check and the result load
// one request at a time: a new one is taken only once the last result is loaded; the single
// write port of the tree memory and the shared compare unit set the per-level step
// reset: synchronous; afterwards all 2048 tree nodes are initialized, no requests then
module prefix_code_buddy_allocator_top (
  input  logic                       clk,
  input  logic                       rst,
  // request channel
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [bba_pkg::LEN_W-1:0]  code_length,
  // result channel
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [bba_pkg::CODE_W-1:0] code_bits,
  output logic                       failed
);

  // memory control from the sequencer
  bba_pkg::mem_req_t          mem_req;
  logic [bba_pkg::LEN_W-1:0]  rd_data_a;
  logic [bba_pkg::LEN_W-1:0]  rd_data_b;
  logic                       mem_busy;

  // operands and results of the shared compare unit
  logic [bba_pkg::LEN_W-1:0]  op_a;
  logic [bba_pkg::LEN_W-1:0]  op_b;
  logic [bba_pkg::LEN_W-1:0]  op_len;
  logic                       go_right;
  logic [bba_pkg::LEN_W-1:0]  min_val;

  // node tree: min free length per subtree, two read ports, one write port
  bba_tree_mem u_tree_mem (
    .clk       (clk),
    .rst       (rst),
    .mem_req   (mem_req),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .busy      (mem_busy)
  );

  // shared unit: turn choice on the way down, min of children on the way up
  bba_step_unit u_step_unit (
    .a        (op_a),
    .b        (op_b),
    .len      (op_len),
    .go_right (go_right),
    .min_val  (min_val)
  );

  // sequencer: check, descent, ancestor rebuild, result register
  bba_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .code_length (code_length),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .code_bits   (code_bits),
    .failed      (failed),
    .mem_busy    (mem_busy),
    .rd_data_a   (rd_data_a),
    .rd_data_b   (rd_data_b),
    .mem_req     (mem_req),
    .op_a        (op_a),
    .op_b        (op_b),
    .op_len      (op_len),
    .go_right    (go_right),
    .min_val     (min_val)
  );

  // a failed result always carries an all-zero code
  a_fail_zero_code: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && failed) |-> (code_bits == '0))
    else $error("failed result with nonzero code");

  // a request transfer makes the block busy on the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while previous one in flight");

  // no request transfer while the tree is being initialized
  a_no_req_in_init: assert property (@(posedge clk) disable iff (rst)
    mem_busy |-> req_stall)
    else $error("request accepted during tree init");

endmodule

// File: hw/rtl/bba_tree_mem.sv
module bba_tree_mem (
  input  logic                     clk,
  input  logic                     rst,
  input  bba_pkg::mem_req_t        mem_req,
  output logic [bba_pkg::LEN_W-1:0] rd_data_a,
  output logic [bba_pkg::LEN_W-1:0] rd_data_b,
  output logic                     busy
);

  logic [bba_pkg::LEN_W-1:0]  mem [bba_pkg::NODE_COUNT];
  logic [bba_pkg::NODE_W-1:0] clr_addr;
  logic [bba_pkg::LEN_W-1:0]  clr_depth;
  logic                       clearing;

  logic                       we_eff;
  logic [bba_pkg::NODE_W-1:0] wr_addr_eff;
  logic [bba_pkg::LEN_W-1:0]  wr_data_eff;
  logic                       level_end;

  // last node of a tree level (all ones); entry 0, the root and level one all hold 1
  assign level_end = ((clr_addr & (clr_addr + bba_pkg::NODE_W'(1))) == '0) &&
                     (clr_addr[bba_pkg::NODE_W-1:1] != '0);

  assign we_eff      = clearing | mem_req.we;
  assign wr_addr_eff = clearing ? clr_addr  : mem_req.wr_addr;
  assign wr_data_eff = clearing ? clr_depth : mem_req.wr_data;
  assign busy        = clearing;

  // init sweep writes each node's depth
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      clr_depth <= bba_pkg::LEN_W'(1);
    end else if (clearing) begin
      clr_addr <= clr_addr + bba_pkg::NODE_W'(1);
      if (level_end) begin
        clr_depth <= clr_depth + bba_pkg::LEN_W'(1);
      end
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we_eff) begin
      mem[wr_addr_eff] <= wr_data_eff;
    end
    rd_data_a <= mem[mem_req.rd_addr_a];
    rd_data_b <= mem[mem_req.rd_addr_b];
  end

endmodule

// File: hw/rtl/bba_step_unit.sv
module bba_step_unit (
  input  logic [bba_pkg::LEN_W-1:0] a,
  input  logic [bba_pkg::LEN_W-1:0] b,
  input  logic [bba_pkg::LEN_W-1:0] len,
  output logic                      go_right,
  output logic [bba_pkg::LEN_W-1:0] min_val
);

  logic a_lt_b;

  // one comparator serves both the turn choice and the min rebuild
  assign a_lt_b  = (a < b);
  assign min_val = a_lt_b ? a : b;

  always_comb begin
    if (a > len) begin
      go_right = 1'b1;
    end else if (b > len) begin
      go_right = 1'b0;
    end else begin
      go_right = a_lt_b;
    end
  end

endmodule

// File: hw/rtl/bba_seq.sv
module bba_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [bba_pkg::LEN_W-1:0]  code_length,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [bba_pkg::CODE_W-1:0] code_bits,
  output logic                       failed,
  input  logic                       mem_busy,
  input  logic [bba_pkg::LEN_W-1:0]  rd_data_a,
  input  logic [bba_pkg::LEN_W-1:0]  rd_data_b,
  output bba_pkg::mem_req_t          mem_req,
  output logic [bba_pkg::LEN_W-1:0]  op_a,
  output logic [bba_pkg::LEN_W-1:0]  op_b,
  output logic [bba_pkg::LEN_W-1:0]  op_len,
  input  logic                       go_right,
  input  logic [bba_pkg::LEN_W-1:0]  min_val
);

  bba_pkg::state_t state, state_next;

  logic [bba_pkg::LEN_W-1:0]  len, len_next;
  logic [bba_pkg::NODE_W-1:0] pos, pos_next;
  logic [bba_pkg::CODE_W-1:0] code, code_next;
  logic [bba_pkg::CODE_W-1:0] bit_sel, bit_sel_next;
  logic [bba_pkg::LVL_W-1:0]  level, level_next;
  logic [bba_pkg::LEN_W-1:0]  cur, cur_next;
  logic                       res_fail, res_fail_next;
  logic                       rsp_valid_next;
  logic [bba_pkg::CODE_W-1:0] code_bits_next;
  logic                       failed_next;

  // value of the sibling not taken, one per level
  logic [bba_pkg::LEN_W-1:0]  sib [bba_pkg::MAX_DEPTH];
  logic [bba_pkg::SIB_W-1:0]  sib_idx;
  logic                       sib_we;
  logic [bba_pkg::LEN_W-1:0]  sib_wdata;
  logic [bba_pkg::NODE_W-1:0] new_pos;

  assign req_stall = (state != bba_pkg::ST_IDLE) || mem_busy;
  assign sib_idx   = bba_pkg::SIB_W'(level - bba_pkg::LVL_W'(1));
  assign new_pos   = {pos[bba_pkg::NODE_W-2:0], go_right};
  assign op_len    = len;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bba_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    len       <= len_next;
    pos       <= pos_next;
    code      <= code_next;
    bit_sel   <= bit_sel_next;
    level     <= level_next;
    cur       <= cur_next;
    res_fail  <= res_fail_next;
    code_bits <= code_bits_next;
    failed    <= failed_next;
    if (sib_we) begin
      sib[sib_idx] <= sib_wdata;
    end
  end

  always_comb begin
    state_next        = state;
    len_next          = len;
    pos_next          = pos;
    code_next         = code;
    bit_sel_next      = bit_sel;
    level_next        = level;
    cur_next          = cur;
    res_fail_next     = res_fail;
    rsp_valid_next    = rsp_valid & rsp_stall;
    code_bits_next    = code_bits;
    failed_next       = failed;
    sib_we            = 1'b0;
    sib_wdata         = rd_data_b;
    op_a              = cur;
    op_b              = sib[sib_idx];
    mem_req.rd_addr_a = bba_pkg::ROOT_NODE;
    mem_req.rd_addr_b = bba_pkg::ROOT_NODE;
    mem_req.we        = 1'b0;
    mem_req.wr_addr   = pos;
    mem_req.wr_data   = min_val;

    case (state)
      bba_pkg::ST_IDLE: begin
        if (req_valid && !mem_busy) begin
          len_next     = code_length;
          pos_next     = bba_pkg::ROOT_NODE;
          code_next    = '0;
          bit_sel_next = {1'b1, {(bba_pkg::CODE_W-1){1'b0}}};
          level_next   = bba_pkg::LVL_W'(1);
          state_next   = bba_pkg::ST_CHECK;
        end
      end

      bba_pkg::ST_CHECK: begin
        // root value now on port a
        if ((len == '0) || (len > bba_pkg::LEN_W'(bba_pkg::MAX_DEPTH)) ||
            (len < rd_data_a)) begin
          res_fail_next = 1'b1;
          code_next     = '0;
          state_next    = bba_pkg::ST_DONE;
        end else begin
          res_fail_next     = 1'b0;
          mem_req.rd_addr_a = {pos[bba_pkg::NODE_W-2:0], 1'b0};
          mem_req.rd_addr_b = {pos[bba_pkg::NODE_W-2:0], 1'b1};
          state_next        = bba_pkg::ST_DESC;
        end
      end

      bba_pkg::ST_DESC: begin
        op_a         = rd_data_a;
        op_b         = rd_data_b;
        sib_we       = 1'b1;
        sib_wdata    = go_right ? rd_data_a : rd_data_b;
        code_next    = code | (go_right ? bit_sel : '0);
        bit_sel_next = bit_sel >> 1;
        if (bba_pkg::LEN_W'(level) == len) begin
          // leaf reached: mark it, pos already holds its parent
          mem_req.we      = 1'b1;
          mem_req.wr_addr = new_pos;
          mem_req.wr_data = bba_pkg::EXHAUSTED;
          cur_next        = bba_pkg::EXHAUSTED;
          state_next      = bba_pkg::ST_ASC;
        end else begin
          pos_next          = new_pos;
          mem_req.rd_addr_a = {new_pos[bba_pkg::NODE_W-2:0], 1'b0};
          mem_req.rd_addr_b = {new_pos[bba_pkg::NODE_W-2:0], 1'b1};
          level_next        = level + bba_pkg::LVL_W'(1);
        end
      end

      bba_pkg::ST_ASC: begin
        mem_req.we = 1'b1;
        cur_next   = min_val;
        pos_next   = pos >> 1;
        if (level == bba_pkg::LVL_W'(1)) begin
          state_next = bba_pkg::ST_DONE;
        end else begin
          level_next = level - bba_pkg::LVL_W'(1);
        end
      end

      bba_pkg::ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next = 1'b1;
          code_bits_next = code;
          failed_next    = res_fail;
          state_next     = bba_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = bba_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: bench/tb_prefix_code_buddy_allocator_top.sv
`timescale 1ns / 1ps

module tb_prefix_code_buddy_allocator_top;
  import bba_pkg::*;

  localparam int  N_REQUESTS  = 1350;
  localparam int  QUIET_LIMIT = 4 * NODE_COUNT + 1000;
  localparam logic REFUSED    = 1'b1;
  localparam logic GRANTED    = 1'b0;

  // one expected result: the code handed out and the refusal flag
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              failed;
  } code_result_t;

  // directed stimulus row; typed rows carry their expected result,
  // the rest are checked against the tree model
  typedef struct {
    logic [LEN_W-1:0]  len;
    bit                typed;
    logic [CODE_W-1:0] want_code;
    logic              want_failed;
  } request_row_t;

  localparam int DIRECTED_ROWS = 17;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  logic [LEN_W-1:0]  code_length = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  logic [CODE_W-1:0] code_bits;
  logic              failed;

  prefix_code_buddy_allocator_top uut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .code_length (code_length),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .code_bits   (code_bits),
    .failed      (failed)
  );

  // tree model: shortest free code length below each node
  logic [LEN_W-1:0] free_len [NODE_COUNT];
  // results still owed by the block, oldest first
  code_result_t     pending_codes [$];

  int mismatch_count = 0;
  int requests_sent  = 0;
  int results_seen   = 0;
  int codes_granted  = 0;
  int codes_refused  = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  bit tree_filled    = 1'b0;
  bit all_ones_seen  = 1'b0;

  // directed part: illegal lengths, a fresh-tree allocation, then legal lengths from
  // MAX_DEPTH down to 3 and two deep ones so the walk sees skips, ties and larger-value turns
  request_row_t directed_rows [DIRECTED_ROWS] = '{
    '{5'd0,                 1'b1, '0, REFUSED},  // zero length
    '{5'd31,                1'b1, '0, REFUSED},  // all input bits set
    '{LEN_W'(MAX_DEPTH + 1), 1'b1, '0, REFUSED}, // just past the deepest level
    '{5'd16,                1'b1, '0, REFUSED},
    '{5'd21,                1'b1, '0, REFUSED},
    '{LEN_W'(MAX_DEPTH),    1'b1, '0, GRANTED},  // fresh tree: ties go left all the way
    '{LEN_W'(MAX_DEPTH),    1'b0, '0, GRANTED},
    '{5'd9,                 1'b0, '0, GRANTED},
    '{5'd8,                 1'b0, '0, GRANTED},
    '{5'd7,                 1'b0, '0, GRANTED},
    '{5'd6,                 1'b0, '0, GRANTED},
    '{5'd5,                 1'b0, '0, GRANTED},
    '{5'd4,                 1'b0, '0, GRANTED},
    '{5'd3,                 1'b0, '0, GRANTED},
    '{5'd15,                1'b1, '0, REFUSED},
    '{LEN_W'(MAX_DEPTH),    1'b0, '0, GRANTED},
    '{5'd9,                 1'b0, '0, GRANTED}
  };

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // single reset at the start
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // every node starts free at its own depth, the root at 1
  function automatic void init_free_len();
    free_len[0] = 5'd1;
    free_len[1] = 5'd1;
    for (int i = 2; i < NODE_COUNT; i++)
      free_len[i] = LEN_W'($clog2(i + 1) - 1);
  endfunction

  // walk down for one request, mark the node taken and refresh its ancestors
  function automatic code_result_t predict_allocation(input logic [LEN_W-1:0] len);
    code_result_t     res;
    int unsigned      pos;
    logic [LEN_W-1:0] lv;
    logic [LEN_W-1:0] rv;
    logic             go_right;
    res.code   = '0;
    res.failed = GRANTED;
    // illegal length, or nothing that short is free anywhere
    if (len == 0 || len > MAX_DEPTH || len < free_len[1]) begin
      res.failed = REFUSED;
      return res;
    end
    pos = 1;
    for (int lvl = 1; lvl <= len; lvl++) begin
      lv = free_len[2 * pos];
      rv = free_len[2 * pos + 1];
      // skip a child that cannot fit, otherwise take the larger value, tie left
      if (lv > len)
        go_right = 1'b1;
      else if (rv > len)
        go_right = 1'b0;
      else
        go_right = (lv < rv);
      if (go_right) begin
        pos = 2 * pos + 1;
        res.code[MAX_DEPTH - lvl] = 1'b1;
      end else begin
        pos = 2 * pos;
      end
    end
    free_len[pos] = EXHAUSTED;
    pos = pos >> 1;
    while (pos != 0) begin
      lv = free_len[2 * pos];
      rv = free_len[2 * pos + 1];
      free_len[pos] = (lv < rv) ? lv : rv;
      pos = pos >> 1;
    end
    return res;
  endfunction

  // one request transfer; valid is left high so back-to-back requests need
  // no extra edge, and is lowered only when a gap is drawn
  task automatic send_request(input logic [LEN_W-1:0] len, input bit typed,
                              input code_result_t typed_want);
    int           gap;
    code_result_t predicted;
    // every fifth stretch of requests runs without gaps
    gap = (((requests_sent / 80) % 5) == 4) ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid   <= 1'b1;
    code_length <= len;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    // transfer taken at this edge: advance the tree model
    predicted = predict_allocation(len);
    pending_codes.push_back(typed ? typed_want : predicted);
    requests_sent++;
    if (predicted.failed)
      codes_refused++;
    else
      codes_granted++;
    if (!predicted.failed && predicted.code == '1)
      all_ones_seen = 1'b1;
    if (free_len[1] == EXHAUSTED)
      tree_filled = 1'b1;
  endtask

  // result side: check each transfer, then draw a fresh stall for the next one
  always @(posedge clk) begin
    int           next_hold;
    code_result_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_codes.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: code_bits=%0d failed=%0b",
                                    code_bits, failed));
        end else begin
          want = pending_codes.pop_front();
          if (code_bits !== want.code)
            report_mismatch($sformatf("result %0d code_bits got %0d want %0d",
                                      results_seen, code_bits, want.code));
          if (failed !== want.failed)
            report_mismatch($sformatf("result %0d failed got %0b want %0b",
                                      results_seen, failed, want.failed));
        end
        results_seen++;
        // stall-free stretch offset from the request side's one
        next_hold = (((results_seen / 80) % 5) == 2) ? 0 : $urandom_range(0, 7);
      end else begin
        next_hold = (hold_left > 0) ? hold_left - 1 : 0;
      end
      hold_left <= next_hold;
      rsp_stall <= (next_hold != 0);
    end
  end

  // watchdog: too long without any transfer means the block has hung
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: %0d cycles with no transfer", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int               sel;
    int               floor_len;
    logic [LEN_W-1:0] len;
    code_result_t     typed_want;
    init_free_len();
    @(posedge clk);
    while (rst) @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      typed_want.code   = directed_rows[i].want_code;
      typed_want.failed = directed_rows[i].want_failed;
      send_request(directed_rows[i].len, directed_rows[i].typed, typed_want);
    end

    // random part: mostly deep allocations that fill the tree slowly, some
    // lengths at or above the root value, some that may be below it, and a
    // little noise of illegal lengths
    typed_want = '0;
    while (requests_sent < N_REQUESTS) begin
      sel = $urandom_range(0, 99);
      floor_len = (free_len[1] > MAX_DEPTH) ? MAX_DEPTH : free_len[1];
      if (sel < 60)
        len = LEN_W'(MAX_DEPTH);
      else if (sel < 75)
        len = LEN_W'($urandom_range(MAX_DEPTH - 2, MAX_DEPTH - 1));
      else if (sel < 85)
        len = LEN_W'($urandom_range(floor_len, MAX_DEPTH));
      else if (sel < 93)
        len = LEN_W'($urandom_range(1, MAX_DEPTH));
      else begin
        sel = $urandom_range(MAX_DEPTH + 1, 32);
        len = (sel == 32) ? '0 : LEN_W'(sel);
      end
      send_request(len, 1'b0, typed_want);
    end
    req_valid <= 1'b0;

    // drain, then give a late or extra result time to show up
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (2 * MAX_DEPTH + 8) @(posedge clk);

    $display("covered %0d requests (%0d directed): %0d codes granted, %0d refused",
             requests_sent, DIRECTED_ROWS, codes_granted, codes_refused);
    $display("tree filled to capacity: %0s, all-ones code granted: %0s",
             tree_filled ? "yes" : "no", all_ones_seen ? "yes" : "no");
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_tree_mem.sv
hw/rtl/bba_step_unit.sv
hw/rtl/bba_seq.sv
hw/rtl/prefix_code_buddy_allocator_top.sv
bench/tb_prefix_code_buddy_allocator_top.sv
